// ===== sv/midpoint_ellipse_rasterizer_top_macros.svh =====
// Assertion macros shared by the ellipse rasterizer RTL.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_TOP_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MER_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mer_pkg.sv =====
// Shared types and constants of the midpoint ellipse rasterizer.
package mer_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int COLOR_W        = 24;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  // Register index field of the configuration address (paddr[2]).
  localparam logic [CFG_ADDR_W-3:0] REG_PIXEL_COLOR = '0;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic      valid;
    cmd_kind_t kind;
  } cmd_head_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// ===== sv/mer_ifs.sv =====
// Request and pixel channel interfaces of the ellipse rasterizer.
interface mer_in_if #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic        [COORD_BITS-2:0] radius_x;
  logic        [COORD_BITS-2:0] radius_y;

  modport source (output valid, op, center_x, center_y, radius_x, radius_y, input ready);
  modport sink   (input valid, op, center_x, center_y, radius_x, radius_y, output ready);
endinterface

interface mer_pix_if #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
  import mer_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] pixel_x;
  logic signed [COORD_BITS:0] pixel_y;
  logic [COLOR_W-1:0]         color;
  logic                       last_of_run;
  logic                       ellipse_done;

  modport source (output valid, pixel_x, pixel_y, color, last_of_run, ellipse_done,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, color, last_of_run, ellipse_done,
                  output ready);
endinterface

// ===== sv/mer_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
module mer_front #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  mer_in_if.sink                       in_ch,
  output mer_pkg::cmd_head_t           head,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] cmd_cx,
  output logic signed [COORD_BITS-1:0] cmd_cy,
  output logic        [COORD_BITS-2:0] cmd_rx,
  output logic        [COORD_BITS-2:0] cmd_ry
);
  import mer_pkg::*;

  localparam int QD    = 2;
  localparam int PTR_W = $clog2(QD);
  localparam int CNT_W = $clog2(QD + 1);

  cmd_kind_t                    kind_q [QD];
  logic signed [COORD_BITS-1:0] cx_q   [QD];
  logic signed [COORD_BITS-1:0] cy_q   [QD];
  logic        [COORD_BITS-2:0] rx_q   [QD];
  logic        [COORD_BITS-2:0] ry_q   [QD];

  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             take;
  cmd_kind_t        in_kind;

  assign in_kind     = in_ch.op ? CMD_ADVANCE : CMD_START;
  assign in_ch.ready = (cnt_r != CNT_W'(QD));
  assign push        = in_ch.valid && in_ch.ready;
  assign head.valid  = (cnt_r != '0);
  assign take        = pop && head.valid;

  assign head.kind = kind_q[rd_ptr_r];
  assign cmd_cx    = cx_q[rd_ptr_r];
  assign cmd_cy    = cy_q[rd_ptr_r];
  assign cmd_rx    = rx_q[rd_ptr_r];
  assign cmd_ry    = ry_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (take) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wr_ptr_r] <= in_kind;
      cx_q[wr_ptr_r]   <= in_ch.center_x;
      cy_q[wr_ptr_r]   <= in_ch.center_y;
      rx_q[wr_ptr_r]   <= in_ch.radius_x;
      ry_q[wr_ptr_r]   <= in_ch.radius_y;
    end
  end

endmodule

// ===== sv/mer_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, for the ellipse setup products.
module mer_mul #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [2*(COORD_BITS-1)-1:0]         a,
  input  logic [COORD_BITS-2:0]               b,
  output logic [3*(COORD_BITS-1)-1:0]         prod,
  output mer_pkg::mul_stat_t                  stat
);
  import mer_pkg::*;

  localparam int RAD_W  = COORD_BITS - 1;
  localparam int PROD_W = 3 * RAD_W;
  localparam int CNT_W  = $clog2(RAD_W + 1);

  logic [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0] mcand_r;
  logic [RAD_W-1:0]  mplier_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(RAD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= PROD_W'(a);
      mplier_r <= b;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

endmodule

// ===== sv/mer_back.sv =====
// Back end: setup products, midpoint stepping and pixel emission.
`include "midpoint_ellipse_rasterizer_top_macros.svh"

module mer_back #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mer_pkg::cmd_head_t           head,
  output logic                         pop,
  input  logic signed [COORD_BITS-1:0] cmd_cx,
  input  logic signed [COORD_BITS-1:0] cmd_cy,
  input  logic        [COORD_BITS-2:0] cmd_rx,
  input  logic        [COORD_BITS-2:0] cmd_ry,
  input  logic [mer_pkg::COLOR_W-1:0]  pixel_color,
  mer_pix_if.source                    out_ch
);
  import mer_pkg::*;

  localparam int RAD_W   = COORD_BITS - 1;
  localparam int SQ_W    = 2 * RAD_W;
  localparam int PROD_W  = 3 * RAD_W;
  localparam int BOUND_W = PROD_W + 1;
  localparam int STEP_W  = BOUND_W + 1;
  localparam int DEC_W   = STEP_W + 1;
  localparam int PIX_W   = COORD_BITS + 1;

  localparam logic [2:0] EMIT_LAST_START = 3'd7;
  localparam logic [2:0] EMIT_LAST_STEP  = 3'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_INIT, S_TERMS, S_DEC, S_SETTLE, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MS_SQX, MS_SQY, MS_BND0, MS_BND1
  } mul_step_t;

  state_t    state_r;
  mul_step_t mul_idx_r;
  logic      active_r;
  logic      region_r;
  logic      emit_start_r;
  logic      run_done_r;
  logic [2:0] emit_cnt_r;

  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic        [RAD_W-1:0]      rx_r, ry_r;
  logic        [SQ_W-1:0]       sqx_r, sqy_r;
  logic        [BOUND_W-1:0]    bound0_r, bound1_r;
  logic        [SQ_W-1:0]       major_r, minor_r;
  logic signed [DEC_W-1:0]      dec_r;
  logic signed [STEP_W-1:0]     sx_r, sy_r;
  logic signed [COORD_BITS-1:0] along_r, across_r;
  logic signed [COORD_BITS-1:0] emit_u_r, emit_v_r;

  logic                  out_valid_r;
  logic signed [PIX_W-1:0] out_x_r, out_y_r;
  logic [COLOR_W-1:0]    out_color_r;
  logic                  out_last_r;
  logic                  out_done_r;

  // multiplier hookup
  logic              mul_start;
  mul_step_t         launch_idx;
  logic [SQ_W-1:0]   mul_a;
  logic [RAD_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_prod;
  mul_stat_t         mul_stat;

  // region setup
  logic                   init_k;
  logic                   init_any;
  logic [SQ_W-1:0]        init_a2, init_b2;
  logic [BOUND_W-1:0]     init_bnd;
  logic [RAD_W-1:0]       init_b;
  logic signed [DEC_W-1:0] init_base, init_dec;

  // step arithmetic
  logic signed [STEP_W-1:0] sx_next;
  logic signed [DEC_W-1:0]  dec_sum;
  logic                     has_step;

  // pixel generation
  logic signed [COORD_BITS-1:0] cur_u, cur_v;
  logic signed [PIX_W-1:0]      off_x, off_y, pix_x, pix_y;
  logic                         emit_last;
  logic                         out_free;

  mer_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  assign pop = (state_r == S_IDLE) && head.valid;

  assign mul_start = (pop && head.kind == CMD_START) ||
                     (state_r == S_MUL && mul_stat.done && mul_idx_r != MS_BND1);
  assign launch_idx = (state_r == S_IDLE) ? MS_SQX : mul_step_t'(2'(mul_idx_r) + 2'd1);

  always_comb begin
    unique case (launch_idx)
      MS_SQX: begin
        mul_a = SQ_W'(cmd_rx);
        mul_b = cmd_rx;
      end
      MS_SQY: begin
        mul_a = SQ_W'(ry_r);
        mul_b = ry_r;
      end
      MS_BND0: begin
        mul_a = sqx_r;
        mul_b = ry_r;
      end
      MS_BND1: begin
        mul_a = sqy_r;
        mul_b = rx_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Region setup: d0 = b^2 - a^2*b + a^2/4, rounded toward zero; a^2*b is half the bound.
  assign init_any = (bound0_r != '0) || (bound1_r != '0);
  assign init_k   = (state_r == S_SETTLE) ? 1'b1 : (bound0_r == '0);
  assign init_a2  = init_k ? sqy_r : sqx_r;
  assign init_b2  = init_k ? sqx_r : sqy_r;
  assign init_bnd = init_k ? bound1_r : bound0_r;
  assign init_b   = init_k ? rx_r : ry_r;
  assign init_base = DEC_W'(init_b2) - DEC_W'(init_bnd[BOUND_W-1:1])
                   + DEC_W'(init_a2[SQ_W-1:2]);
  assign init_dec  = (init_base[DEC_W-1] && init_a2[1:0] != 2'b00) ?
                     init_base + DEC_W'(1) : init_base;

  assign sx_next  = sx_r + STEP_W'({minor_r, 1'b0});
  assign dec_sum  = dec_r + DEC_W'(minor_r) + DEC_W'(sx_r)
                  - (dec_r[DEC_W-1] ? DEC_W'(0) : DEC_W'(sy_r));
  assign has_step = (sx_r < sy_r);

  // Pixel k of a run: bit 0 mirrors u, bit 1 mirrors v, bit 2 picks the second axis quad.
  always_comb begin
    if (emit_start_r) begin
      cur_u = emit_cnt_r[2] ? COORD_BITS'({1'b0, rx_r}) : '0;
      cur_v = emit_cnt_r[2] ? '0 : COORD_BITS'({1'b0, ry_r});
    end else begin
      cur_u = emit_u_r;
      cur_v = emit_v_r;
    end
    off_x = emit_cnt_r[0] ? -PIX_W'(cur_u) : PIX_W'(cur_u);
    off_y = emit_cnt_r[1] ? -PIX_W'(cur_v) : PIX_W'(cur_v);
    pix_x = PIX_W'(cx_r) + off_x;
    pix_y = PIX_W'(cy_r) + off_y;
  end

  assign emit_last = (emit_cnt_r == (emit_start_r ? EMIT_LAST_START : EMIT_LAST_STEP));
  assign out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = out_x_r;
  assign out_ch.pixel_y      = out_y_r;
  assign out_ch.color        = out_color_r;
  assign out_ch.last_of_run  = out_last_r;
  assign out_ch.ellipse_done = out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mul_idx_r    <= MS_SQX;
      active_r     <= 1'b0;
      region_r     <= 1'b0;
      emit_start_r <= 1'b0;
      run_done_r   <= 1'b0;
      emit_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            if (head.kind == CMD_START) begin
              active_r  <= 1'b0;
              mul_idx_r <= MS_SQX;
              state_r   <= S_MUL;
            end else if (active_r) begin
              state_r <= S_TERMS;
            end
            // drop an advance while idle
          end
        end
        S_MUL: begin
          if (mul_stat.done) begin
            if (mul_idx_r == MS_BND1) begin
              state_r <= S_INIT;
            end else begin
              mul_idx_r <= launch_idx;
            end
          end
        end
        S_INIT: begin
          active_r     <= init_any;
          region_r     <= init_k;
          run_done_r   <= !init_any;
          emit_start_r <= 1'b1;
          emit_cnt_r   <= '0;
          state_r      <= S_EMIT;
        end
        S_TERMS: begin
          state_r <= S_DEC;
        end
        S_DEC: begin
          emit_start_r <= 1'b0;
          emit_cnt_r   <= '0;
          if (has_step) begin
            run_done_r <= 1'b0;
            state_r    <= S_EMIT;
          end else if (!region_r) begin
            state_r <= S_SETTLE;
          end else begin
            active_r   <= 1'b0;
            run_done_r <= 1'b1;
            state_r    <= S_EMIT;
          end
        end
        S_SETTLE: begin
          region_r   <= 1'b1;
          active_r   <= (bound1_r != '0);
          run_done_r <= (bound1_r == '0);
          state_r    <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= pix_x;
            out_y_r     <= pix_y;
            out_color_r <= pixel_color;
            out_last_r  <= emit_last;
            out_done_r  <= emit_last && run_done_r;
            emit_cnt_r  <= emit_cnt_r + 3'd1;
            if (emit_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (pop && head.kind == CMD_START) begin
          cx_r <= cmd_cx;
          cy_r <= cmd_cy;
          rx_r <= cmd_rx;
          ry_r <= cmd_ry;
        end
      end
      S_MUL: begin
        if (mul_stat.done) begin
          unique case (mul_idx_r)
            MS_SQX:  sqx_r    <= mul_prod[SQ_W-1:0];
            MS_SQY:  sqy_r    <= mul_prod[SQ_W-1:0];
            MS_BND0: bound0_r <= {mul_prod, 1'b0};
            MS_BND1: bound1_r <= {mul_prod, 1'b0};
            default: sqx_r    <= sqx_r;
          endcase
        end
      end
      S_INIT, S_SETTLE: begin
        major_r  <= init_a2;
        minor_r  <= init_b2;
        dec_r    <= init_dec;
        sx_r     <= '0;
        sy_r     <= STEP_W'(init_bnd);
        along_r  <= '0;
        across_r <= COORD_BITS'({1'b0, init_b});
      end
      S_TERMS: begin
        along_r <= along_r + 1'b1;
        sx_r    <= sx_next;
        if (!dec_r[DEC_W-1]) begin
          across_r <= across_r - 1'b1;
          sy_r     <= sy_r - STEP_W'({major_r, 1'b0});
        end
      end
      S_DEC: begin
        dec_r    <= dec_sum;
        emit_u_r <= region_r ? across_r : along_r;
        emit_v_r <= region_r ? along_r : across_r;
      end
      S_EMIT: begin
        dec_r <= dec_r;
      end
      default: begin
        dec_r <= dec_r;
      end
    endcase
  end

  `MER_ASSERT_IMPL(a_mul_done_in_mul, mul_stat.done, state_r == S_MUL, "product finished outside setup")
  `MER_ASSERT_NEXT(a_mul_runs, mul_start, mul_stat.busy, "multiplier did not start")
  `MER_ASSERT_IMPL(a_done_goes_idle, state_r == S_EMIT && run_done_r, !active_r, "ellipse ended while still active")
  `MER_ASSERT_IMPL(a_step_run_len, state_r == S_EMIT && !emit_start_r, emit_cnt_r[2] == 1'b0, "step run longer than four pixels")

endmodule

// ===== sv/midpoint_ellipse_rasterizer_top.sv =====
// Midpoint ellipse rasterizer top level: request queue, stepping engine and color register.
// A start request loads the center and radii, forms the four setup products (a^2, b^2,
// 2a^2b, 2b^2a) on one shared shift-add multiplier, sets up the first region and then
// sends the eight axis pixels one per cycle while the output accepts them. An advance
// request runs a term update, a decision update and four pixels, with a settle step added
// when it crosses into region two; an advance with no ellipse in progress is dropped.
// A two-entry queue in front lets requests arrive while a run is being worked, and the
// pixel output register holds a result while the next one is prepared.
// Write pixel_color at byte address 0 through the APB port only while the block is idle.
module midpoint_ellipse_rasterizer_top #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mer_in_if.sink                         in_ch,
  mer_pix_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mer_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mer_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mer_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import mer_pkg::*;

  logic [COLOR_W-1:0]           pixel_color_r;
  logic                         cfg_hit;
  cmd_head_t                    head;
  logic                         pop;
  logic signed [COORD_BITS-1:0] cmd_cx, cmd_cy;
  logic        [COORD_BITS-2:0] cmd_rx, cmd_ry;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == REG_PIXEL_COLOR);
  assign prdata  = cfg_hit ? CFG_DATA_W'(pixel_color_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_color_r <= '0;
    end else if (psel && penable && pwrite && cfg_hit) begin
      pixel_color_r <= pwdata[COLOR_W-1:0];
    end
  end

  mer_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .head   (head),
    .pop    (pop),
    .cmd_cx (cmd_cx),
    .cmd_cy (cmd_cy),
    .cmd_rx (cmd_rx),
    .cmd_ry (cmd_ry)
  );

  mer_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .pop         (pop),
    .cmd_cx      (cmd_cx),
    .cmd_cy      (cmd_cy),
    .cmd_rx      (cmd_rx),
    .cmd_ry      (cmd_ry),
    .pixel_color (pixel_color_r),
    .out_ch      (out_ch)
  );

endmodule

// ===== test/tb_midpoint_ellipse_rasterizer_top.sv =====
// Self-checking testbench of the midpoint ellipse rasterizer: directed table, random ellipses.
module tb_midpoint_ellipse_rasterizer_top;
  import mer_pkg::*;

  localparam int CB           = COORD_BITS_DEF;
  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 50;
  localparam logic [CFG_ADDR_W-1:0] COLOR_ADDR = {REG_PIXEL_COLOR, 2'b00};

  typedef logic signed [CB:0] pixel_coord_t;

  typedef struct packed {
    pixel_coord_t       x;
    pixel_coord_t       y;
    logic [COLOR_W-1:0] rgb;
    logic               run_end;
    logic               shape_end;
  } pixel_t;

  // pinned: expectation read off directly (idle advance: nothing; start: all at center)
  typedef struct packed {
    cmd_kind_t              op;
    logic signed [CB-1:0]   cx;
    logic signed [CB-1:0]   cy;
    logic [CB-2:0]          rx;
    logic [CB-2:0]          ry;
    bit                     pinned;
  } request_row_t;

  request_row_t directed_rows [24] = '{
    '{CMD_ADVANCE, 0, 0, 0, 0, 1'b1},
    '{CMD_START, 0, 0, 0, 0, 1'b1},
    '{CMD_START, 32767, -32768, 0, 0, 1'b1},
    '{CMD_START, -32768, 32767, 0, 32767, 1'b0},
    '{CMD_START, 5, -7, 32767, 0, 1'b0},
    '{CMD_ADVANCE, 1, 2, 3, 4, 1'b1},
    '{CMD_START, 100, 200, 1, 1, 1'b0},
    '{CMD_ADVANCE, -1, -1, 32767, 32767, 1'b0},
    '{CMD_ADVANCE, 0, 0, 0, 0, 1'b0},
    '{CMD_ADVANCE, 0, 0, 0, 0, 1'b1},
    '{CMD_START, 32767, 32767, 32767, 32767, 1'b0},
    '{CMD_ADVANCE, 0, 0, 0, 0, 1'b0},
    '{CMD_ADVANCE, 0, 0, 0, 0, 1'b0},
    '{CMD_ADVANCE, 0, 0, 0, 0, 1'b0},
    '{CMD_START, -32768, -32768, 32767, 1, 1'b0},
    '{CMD_ADVANCE, 0, 0, 0, 0, 1'b0},
    '{CMD_ADVANCE, 0, 0, 0, 0, 1'b0},
    '{CMD_START, 0, 0, 1, 32767, 1'b0},
    '{CMD_ADVANCE, 0, 0, 0, 0, 1'b0},
    '{CMD_ADVANCE, 0, 0, 0, 0, 1'b0},
    '{CMD_START, -3, 4, 3, 2, 1'b0},
    '{CMD_ADVANCE, 0, 0, 0, 0, 1'b0},
    '{CMD_ADVANCE, 0, 0, 0, 0, 1'b0},
    '{CMD_ADVANCE, 0, 0, 0, 0, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mer_in_if  #(.COORD_BITS(CB)) req_ch ();
  mer_pix_if #(.COORD_BITS(CB)) pix_ch ();

  midpoint_ellipse_rasterizer_top #(.COORD_BITS(CB)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_ch),
    .out_ch  (pix_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Rasterizer shadow state
  logic [COLOR_W-1:0] shade = '0;
  longint ell_cx = 0, ell_cy = 0;
  longint rad_x_lat = 0, rad_y_lat = 0;
  longint a_sq = 0, b_sq = 0;
  longint span_bound [2] = '{0, 0};
  longint decision = 0, inc_x = 0, inc_y = 0;
  longint pos_along = 0, pos_across = 0;
  bit     in_region2 = 1'b0;
  bit     drawing = 1'b0;

  pixel_t fresh_pixels [$];
  pixel_t pending_pixels [$];
  int     mismatch_count = 0;
  int     pixels_taken = 0;
  int     cycle_count = 0;
  bit     sender_burst = 1'b0;

  function automatic void emit_quad(longint u, longint v);
    longint su [4];
    longint sv [4];
    pixel_t p;
    su = '{u, -u, u, -u};
    sv = '{v, v, -v, -v};
    for (int k = 0; k < 4; k++) begin
      p.x         = pixel_coord_t'(ell_cx + su[k]);
      p.y         = pixel_coord_t'(ell_cy + sv[k]);
      p.rgb       = shade;
      p.run_end   = 1'b0;
      p.shape_end = 1'b0;
      fresh_pixels.push_back(p);
    end
  endfunction

  function automatic void enter_region(bit second);
    longint a, b, a2, b2, s;
    a  = second ? rad_y_lat : rad_x_lat;
    b  = second ? rad_x_lat : rad_y_lat;
    a2 = a * a;
    b2 = b * b;
    // truncate a^2/4 toward zero in the negative case
    s  = b2 - a2 * b + (a2 >>> 2);
    if (s < 0 && (a2 & 3) != 0)
      s += 1;
    a_sq       = a2;
    b_sq       = b2;
    decision   = s;
    inc_x      = 0;
    inc_y      = span_bound[second];
    pos_along  = 0;
    pos_across = b;
    in_region2 = second;
  endfunction

  function automatic void settle_region();
    if (inc_x < inc_y)
      return;
    if (!in_region2) begin
      enter_region(1'b1);
      if (inc_x < inc_y)
        return;
    end
    drawing = 1'b0;
  endfunction

  function automatic void rasterize_request(cmd_kind_t op, longint cx, longint cy,
                                            longint rx, longint ry);
    fresh_pixels.delete();
    if (op == CMD_START) begin
      ell_cx        = cx;
      ell_cy        = cy;
      rad_x_lat     = rx;
      rad_y_lat     = ry;
      span_bound[0] = 2 * (rx * rx) * ry;
      span_bound[1] = 2 * (ry * ry) * rx;
      emit_quad(0, ry);
      emit_quad(rx, 0);
      fresh_pixels[7].run_end = 1'b1;
      drawing = 1'b1;
      enter_region(1'b0);
      settle_region();
      if (!drawing)
        fresh_pixels[7].shape_end = 1'b1;
    end else if (drawing) begin
      pos_along += 1;
      inc_x     += 2 * b_sq;
      if (decision < 0) begin
        decision += b_sq + inc_x;
      end else begin
        pos_across -= 1;
        inc_y      -= 2 * a_sq;
        decision   += b_sq + inc_x - inc_y;
      end
      if (!in_region2)
        emit_quad(pos_along, pos_across);
      else
        emit_quad(pos_across, pos_along);
      fresh_pixels[3].run_end = 1'b1;
      settle_region();
      if (!drawing)
        fresh_pixels[3].shape_end = 1'b1;
    end
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("[%0d] MISMATCH %s: expected %0d, got %0d", cycle_count, what, want, got);
    mismatch_count++;
  endtask

  // Enter at a falling edge; leave at the falling edge after the request is taken.
  task automatic send_request(cmd_kind_t op, logic signed [CB-1:0] cx, logic signed [CB-1:0] cy,
                              logic [CB-2:0] rx, logic [CB-2:0] ry, bit pinned);
    int     gap;
    pixel_t p;
    if ($urandom_range(0, 15) == 0)
      sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.center_x <= cx;
    req_ch.center_y <= cy;
    req_ch.radius_x <= rx;
    req_ch.radius_y <= ry;
    do @(posedge clk); while (!req_ch.ready);
    rasterize_request(op, cx, cy, rx, ry);
    if (!pinned) begin
      foreach (fresh_pixels[k])
        pending_pixels.push_back(fresh_pixels[k]);
    end else if (op == CMD_START) begin
      for (int k = 0; k < 8; k++) begin
        p.x         = cx;
        p.y         = cy;
        p.rgb       = shade;
        p.run_end   = (k == 7);
        p.shape_end = (k == 7);
        pending_pixels.push_back(p);
      end
    end
    @(negedge clk);
  endtask

  task automatic apb_xfer(bit wr, logic [COLOR_W-1:0] val, output logic [CFG_DATA_W-1:0] rd);
    logic [CFG_DATA_W-1:0] word;
    word                = $urandom;
    word[COLOR_W-1:0]   = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= COLOR_ADDR;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (wr)
      shade = val;
    @(negedge clk);
  endtask

  task automatic set_color(logic [COLOR_W-1:0] rgb);
    logic [CFG_DATA_W-1:0] rd;
    apb_xfer(1'b1, rgb, rd);
    apb_xfer(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[COLOR_W-1:0] !== rgb)
      report_mismatch("pixel_color readback", rgb, rd[COLOR_W-1:0]);
    @(negedge clk);
  endtask

  // Hold until every pixel is back, then let stray idle advances drain.
  task automatic drain_pixels();
    req_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [CB-2:0] pick_radius();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)
      return $urandom_range(0, 32767);
    if (r < 20)
      return $urandom_range(0, 300);
    return $urandom_range(0, 12);
  endfunction

  task automatic run_random_phase(int target);
    int        counted;
    cmd_kind_t op;
    counted = 0;
    while (counted < target) begin
      if (drawing)
        op = ($urandom_range(0, 9) == 0) ? CMD_START : CMD_ADVANCE;
      else
        op = ($urandom_range(0, 6) == 0) ? CMD_ADVANCE : CMD_START;
      // idle advances are noise and do not count
      if (op == CMD_START || drawing)
        counted++;
      send_request(op, $urandom, $urandom, pick_radius(), pick_radius(), 1'b0);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Pixel receiver
  initial begin
    int     wait_cycles;
    bit     burst;
    bit     held;
    pixel_t want;
    burst = 1'b0;
    held  = 1'b0;
    pix_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0)
        burst = !burst;
      wait_cycles = burst ? 0 : $urandom_range(0, 3);
      if (!held && pixels_taken >= HOLD_AT) begin
        held        = 1'b1;
        wait_cycles = HOLD_CYCLES;
      end
      if (wait_cycles > 0) begin
        pix_ch.ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      pix_ch.ready <= 1'b1;
      do @(posedge clk); while (!pix_ch.valid);
      pixels_taken++;
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel, x", 0, pix_ch.pixel_x);
      end else begin
        want = pending_pixels.pop_front();
        if (pix_ch.pixel_x !== want.x)
          report_mismatch("pixel_x", want.x, pix_ch.pixel_x);
        if (pix_ch.pixel_y !== want.y)
          report_mismatch("pixel_y", want.y, pix_ch.pixel_y);
        if (pix_ch.color !== want.rgb)
          report_mismatch("color", want.rgb, pix_ch.color);
        if (pix_ch.last_of_run !== want.run_end)
          report_mismatch("last_of_run", want.run_end, pix_ch.last_of_run);
        if (pix_ch.ellipse_done !== want.shape_end)
          report_mismatch("ellipse_done", want.shape_end, pix_ch.ellipse_done);
      end
      @(negedge clk);
    end
  end

  // Request sender and phase control
  initial begin
    logic [CFG_DATA_W-1:0] rd;
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    req_ch.valid    = 1'b0;
    req_ch.op       = CMD_START;
    req_ch.center_x = '0;
    req_ch.center_y = '0;
    req_ch.radius_x = '0;
    req_ch.radius_y = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // color register comes out of reset as black
    apb_xfer(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[COLOR_W-1:0] !== '0)
      report_mismatch("pixel_color after reset", 0, rd[COLOR_W-1:0]);
    @(negedge clk);

    set_color(24'hFFFFFF);
    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].cx, directed_rows[i].cy,
                   directed_rows[i].rx, directed_rows[i].ry, directed_rows[i].pinned);
    drain_pixels();

    for (int phase = 0; phase < 4; phase++) begin
      set_color(phase == 0 ? 24'h000000 : COLOR_W'($urandom));
      run_random_phase(PHASE_ITEMS);
      drain_pixels();
    end

    if (pending_pixels.size() != 0)
      report_mismatch("pixels never delivered", 0, pending_pixels.size());
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
